/* rtl/core/lgrs_pkg.sv */
// Package: widths, register indexes and the result word type for the row stepper.
package lgrs_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 4096;
  localparam int ROW_W        = MAX_WIDTH;
  localparam int ROWNUM_W     = $clog2(MAX_HEIGHT);
  localparam int GW_W         = 7;
  localparam int GH_W         = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [GW_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 13'd64;

  typedef struct packed {
    logic [ROW_W-1:0]    next_row_bits;
    logic [ROWNUM_W-1:0] row_number;
    logic                end_of_generation;
    logic                generation_stable;
    logic                last_of_burst;
  } res_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

endpackage

/* rtl/core/lgrs_if.sv */
// Interfaces: row input channel and result channel, valid/ready handshake.
interface lgrs_row_if;
  import lgrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_bits;
  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

interface lgrs_res_if;
  import lgrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    next_row_bits;
  logic [ROWNUM_W-1:0] row_number;
  logic                end_of_generation;
  logic                generation_stable;
  logic                last_of_burst;
  modport source (output valid, output next_row_bits, output row_number,
                  output end_of_generation, output generation_stable,
                  output last_of_burst, input ready);
  modport sink   (input valid, input next_row_bits, input row_number,
                  input end_of_generation, input generation_stable,
                  input last_of_burst, output ready);
endinterface

/* rtl/core/life_generation_row_stepper_unit.sv */
// Top level: Game of Life B3/S23 row stepper with 64 cell lanes and a result queue.
//
// Rows enter on in_ch, top row first, one word per row; bit x is column x.
// Results leave on out_ch one row behind the input: each row word causes the
// previous row's next generation, and the last row of a generation also
// causes the bottom row, flagged end_of_generation (and generation_stable
// when no cell changed). last_of_burst marks the final word caused by a row.
// All 64 column lanes evaluate in the cycle a row is accepted; the merge
// stage masks to the grid width and writes one or two words into a
// four-entry result queue. Throughput is one row per cycle while rows cause
// one result and out_ch is not stalled; a last row adds two words, which
// leave by the single read port of the queue. in_ch.ready is high while two
// queue entries are free, so a stalled receiver holds out_ch steady and
// backs up the input once three words wait in the queue. Configuration
// (cfg_idx 0 grid width, 1 grid height) is written by the user only while
// idle; the block does not enforce this. Synchronous reset empties the queue,
// clears the held rows and row count, and sets width and height to 64.
module life_generation_row_stepper_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lgrs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lgrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  lgrs_row_if.sink                         in_ch,
  lgrs_res_if.source                       out_ch
);
  import lgrs_pkg::*;

  logic [GW_W-1:0]     width_r;
  logic [GH_W-1:0]     height_r;
  logic [ROW_W-1:0]    older_r, mid_r;
  logic [ROWNUM_W-1:0] rows_r;
  logic                any_r;

  logic [GW_W-1:0]     w_eff;
  logic [GH_W-1:0]     h_eff;
  logic [ROW_W-1:0]    mask;
  logic [ROW_W-1:0]    row_m;
  logic [ROW_W-1:0]    lane_out;
  logic [ROW_W-1:0]    evo_row;
  logic [ROW_W-1:0]    next_row;
  logic [ROW_W+1:0]    above_p, cur_p, below_p;
  logic                accept, last, have_prev, any_nxt, room2, q_valid;
  push_t               push;
  res_t                res_a, res_b, res0, res1, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= GRID_WIDTH_RST;
      height_r <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_WIDTH:  width_r  <= cfg_wdata[GW_W-1:0];
        REG_GRID_HEIGHT: height_r <= cfg_wdata[GH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0)                      w_eff = GW_W'(1);
    else if (width_r > GW_W'(MAX_WIDTH))    w_eff = GW_W'(MAX_WIDTH);
    else                                    w_eff = width_r;
    if (height_r == '0)                     h_eff = GH_W'(1);
    else if (height_r > GH_W'(MAX_HEIGHT))  h_eff = GH_W'(MAX_HEIGHT);
    else                                    h_eff = height_r;
  end

  assign row_m   = in_ch.row_bits & mask;
  assign above_p = {1'b0, older_r, 1'b0};
  assign cur_p   = {1'b0, mid_r, 1'b0};
  assign below_p = {1'b0, row_m, 1'b0};

  for (genvar x = 0; x < ROW_W; x++) begin : g_lane
    lgrs_lane u_lane (
      .above     (above_p[x+2:x]),
      .cur       (cur_p[x+2:x]),
      .below     (below_p[x+2:x]),
      .alive_nxt (lane_out[x])
    );
    assign mask[x] = (GW_W'(x) < w_eff);
    // border columns keep the current cell
    assign evo_row[x] = mask[x] &
        (((x != 0) && (GW_W'(x + 1) < w_eff)) ? lane_out[x] : mid_r[x]);
  end

  // merge: top and bottom rows are copied, interior rows take the lane results
  always_comb begin
    last      = ({1'b0, rows_r} + GH_W'(1)) >= h_eff;
    have_prev = (rows_r != '0);
    next_row  = (rows_r == ROWNUM_W'(1)) ? mid_r : evo_row;
    any_nxt   = any_r || (have_prev && (next_row != mid_r));

    res0.next_row_bits     = next_row;
    res0.row_number        = rows_r - ROWNUM_W'(1);
    res0.end_of_generation = 1'b0;
    res0.generation_stable = 1'b0;
    res0.last_of_burst     = !last;

    res1.next_row_bits     = row_m;
    res1.row_number        = rows_r;
    res1.end_of_generation = 1'b1;
    res1.generation_stable = !any_nxt;
    res1.last_of_burst     = 1'b1;

    accept      = in_ch.valid && room2;
    push.push_a = accept && (have_prev || last);
    push.push_b = accept && have_prev && last;
    res_a       = have_prev ? res0 : res1;
    res_b       = res1;
  end

  assign in_ch.ready = room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      mid_r   <= '0;
      rows_r  <= '0;
      any_r   <= 1'b0;
    end else if (accept) begin
      if (last) begin
        older_r <= '0;
        mid_r   <= '0;
        rows_r  <= '0;
        any_r   <= 1'b0;
      end else begin
        older_r <= mid_r;
        mid_r   <= row_m;
        rows_r  <= rows_r + ROWNUM_W'(1);
        any_r   <= any_nxt;
      end
    end
  end

  lgrs_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_a    (res_a),
    .data_b    (res_b),
    .pop       (out_ch.ready),
    .head      (head),
    .not_empty (q_valid),
    .room2     (room2)
  );

  assign out_ch.valid             = q_valid;
  assign out_ch.next_row_bits     = head.next_row_bits;
  assign out_ch.row_number        = head.row_number;
  assign out_ch.end_of_generation = head.end_of_generation;
  assign out_ch.generation_stable = head.generation_stable;
  assign out_ch.last_of_burst     = head.last_of_burst;
endmodule

/* rtl/core/lgrs_lane.sv */
// One cell lane: neighbour count and B3/S23 rule for a single column.
module lgrs_lane (
  input  logic [2:0] above,
  input  logic [2:0] cur,
  input  logic [2:0] below,
  output logic       alive_nxt
);
  logic [3:0] cnt;

  always_comb begin
    cnt = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
        + 4'(cur[0]) + 4'(cur[2])
        + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
    alive_nxt = cur[1] ? ((cnt == 4'd2) || (cnt == 4'd3)) : (cnt == 4'd3);
  end
endmodule

/* rtl/core/lgrs_res_fifo.sv */
// Result queue: up to two words written per cycle, one read per cycle.
module lgrs_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  lgrs_pkg::push_t push,
  input  lgrs_pkg::res_t  data_a,
  input  lgrs_pkg::res_t  data_b,
  input  logic            pop,
  output lgrs_pkg::res_t  head,
  output logic            not_empty,
  output logic            room2
);
  import lgrs_pkg::*;

  res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIFO_CNT_W-1:0] n_push;
  logic                  do_pop;

  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    n_push     = FIFO_CNT_W'(push.push_a) + FIFO_CNT_W'(push.push_b);
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + n_push - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem_r[wr_ptr_r] <= data_a;
    end
    if (push.push_b) begin
      mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= data_b;
    end
  end
endmodule

/* rtl/core/lgrs_checker.sv */
// Checker: port-level assertions for the row stepper, bound to the top level.
module lgrs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lgrs_pkg::ROW_W-1:0]    out_bits,
  input logic [lgrs_pkg::ROWNUM_W-1:0] out_rownum,
  input logic                          out_eog,
  input logic                          out_stable,
  input logic                          out_lob
);
  import lgrs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bits) && $stable(out_rownum))
    else $error("result word changed while stalled");

  a_eog_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_eog |-> out_lob)
    else $error("bottom row not marked last of burst");

  a_stable_eog: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stable |-> out_eog)
    else $error("stable flag off the bottom row");
endmodule

bind life_generation_row_stepper_unit lgrs_checker u_lgrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_bits   (out_ch.next_row_bits),
  .out_rownum (out_ch.row_number),
  .out_eog    (out_ch.end_of_generation),
  .out_stable (out_ch.generation_stable),
  .out_lob    (out_ch.last_of_burst)
);

/* test/life_generation_row_stepper_unit_tb.sv */
// Testbench: row stepper results checked word by word against a B3/S23 row predictor.
module life_generation_row_stepper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgrs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lgrs_row_if in_ch();
  lgrs_res_if out_ch();

  life_generation_row_stepper_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of the grid geometry and the held rows
  int unsigned      grid_w;
  int unsigned      grid_h;
  logic [ROW_W-1:0] row_above;
  logic [ROW_W-1:0] row_mid;
  int               rows_taken;
  bit               cells_moved;
  res_t             gen_rows_due[$];

  int bad_words    = 0;
  int rows_sent    = 0;
  int hold_request = 0;
  int burst_left   = 0;
  bit feed_steady  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("life_generation_row_stepper_unit: mismatch");
    $finish;
  end

  function automatic logic [ROW_W-1:0] evolve_cells(logic [ROW_W-1:0] up, logic [ROW_W-1:0] cur,
                                                    logic [ROW_W-1:0] dn, int w);
    logic [ROW_W-1:0] nxt;
    int               n;
    int               x;
    nxt = cur;
    for (x = 1; x + 1 < w; x++) begin
      n = $countones(up[x+1 -: 3]) + $countones(dn[x+1 -: 3]) + int'(cur[x-1]) + int'(cur[x+1]);
      nxt[x] = cur[x] ? (n == 2 || n == 3) : (n == 3);
    end
    return nxt;
  endfunction

  function automatic void life_step_row(logic [ROW_W-1:0] in_bits);
    int               w;
    int               h;
    int               r;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] nxt;
    bit               last;
    res_t             word;
    w = (grid_w == 0) ? 1 : ((grid_w > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w));
    h = (grid_h == 0) ? 1 : ((grid_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h));
    mask = (w >= ROW_W) ? '1 : ((64'd1 << w) - 64'd1);
    row = in_bits & mask;
    r = rows_taken;
    last = (r + 1 >= h);
    if (r >= 1) begin
      nxt = (r == 1) ? row_mid : (evolve_cells(row_above, row_mid, row, w) & mask);
      if (nxt != row_mid) cells_moved = 1'b1;
      word.next_row_bits     = nxt;
      word.row_number        = ROWNUM_W'(r - 1);
      word.end_of_generation = 1'b0;
      word.generation_stable = 1'b0;
      word.last_of_burst     = !last;
      gen_rows_due.push_back(word);
    end
    if (last) begin
      word.next_row_bits     = row;
      word.row_number        = ROWNUM_W'(r);
      word.end_of_generation = 1'b1;
      word.generation_stable = !cells_moved;
      word.last_of_burst     = 1'b1;
      gen_rows_due.push_back(word);
      row_above   = '0;
      row_mid     = '0;
      rows_taken  = 0;
      cells_moved = 1'b0;
    end else begin
      row_above  = row_mid;
      row_mid    = row;
      rows_taken = r + 1;
    end
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a & b;
      1: return a | b;
      2: return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
    if (idx == REG_GRID_WIDTH) grid_w = data & 'h7F;
    else if (idx == REG_GRID_HEIGHT) grid_h = data & 'h1FFF;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_row(logic [ROW_W-1:0] bits);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.row_bits <= bits;
    do @(posedge clk); while (!in_ch.ready);
    life_step_row(bits);
    rows_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = (feed_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // first row of a generation makes no word, so allow the pipe to settle
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (gen_rows_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_row('0);
    send_row('1);
    send_row({32{2'b10}});
    send_row({32{2'b01}});
    send_row(64'h8000_0000_0000_0001);
    settle_idle();
    // height dropped below rows already taken: next row closes the generation
    write_reg(REG_GRID_HEIGHT, 3);
    send_row(64'h0123_4567_89AB_CDEF);
    settle_idle();
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_HEIGHT, 0);
    send_row('1);
    send_row(64'h2);
    settle_idle();
    write_reg(REG_GRID_WIDTH, 2);
    write_reg(REG_GRID_HEIGHT, 2);
    send_row('1);
    send_row(64'h1);
    settle_idle();
    // width field 67 saturates; vertical blinker plus border cells
    write_reg(REG_GRID_WIDTH, 13'h1FC3);
    write_reg(REG_GRID_HEIGHT, 5);
    send_row('0);
    send_row(64'h8000_0001_0000_0001);
    send_row(64'h0000_0001_0000_0000);
    send_row(64'h0000_0001_0000_0000);
    send_row('1);
    settle_idle();
    // block still life
    write_reg(REG_GRID_WIDTH, 4);
    write_reg(REG_GRID_HEIGHT, 4);
    send_row(64'h0);
    send_row(64'h6);
    send_row(64'h6);
    send_row(64'h0);
    settle_idle();
    write_reg(REG_SPARE_LO, 13'h1FFF);
    write_reg(REG_SPARE_HI, 1);
    send_row(64'hF);
    send_row(64'h7);
    send_row(64'h2);
    send_row(64'hFFFF_FFFF_FFFF_FFF0);
    settle_idle();
  endtask

  task automatic test_random_generations(int n_rows);
    int               stop_at;
    int unsigned      w;
    int unsigned      h;
    int               span;
    int               cut;
    int               mode;
    int               k;
    logic [ROW_W-1:0] row;
    stop_at = rows_sent + n_rows;
    while (rows_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2);
        1: w = $urandom_range(65, 127);
        2: w = 64;
        default: w = $urandom_range(3, 64);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, 2);
        1: h = $urandom_range(13, 40);
        default: h = $urandom_range(3, 12);
      endcase
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
      span = (h == 0) ? 1 : int'(h);
      // some generations stop early so the next geometry lands mid-generation
      cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, span) : span;
      mode = $urandom_range(0, 5);
      feed_steady = ($urandom_range(0, 4) == 0);
      for (k = 0; k < cut; k++) begin
        case (mode)
          0: row = '0;
          1: row = (k % 4 == 1 || k % 4 == 2) ? {16{4'b0110}} : '0;
          default: row = rand_row();
        endcase
        send_row(row);
      end
      settle_idle();
    end
    feed_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(REG_GRID_WIDTH, 64);
    write_reg(REG_GRID_HEIGHT, 30);
    feed_steady  = 1'b1;
    hold_request = 300;
    repeat (30) send_row(rand_row());
    feed_steady = 1'b0;
    settle_idle();
  endtask

  task automatic test_tallest();
    write_reg(REG_GRID_WIDTH, 16);
    write_reg(REG_GRID_HEIGHT, 13'h1FFF);
    repeat (40) send_row(rand_row());
    settle_idle();
    // lowered height closes the long generation on the next row
    write_reg(REG_GRID_HEIGHT, 3);
    send_row(rand_row());
    settle_idle();
  endtask

  // result side: stall pattern redrawn at random, long hold on request
  initial begin
    int          hold_left;
    int          phase;
    logic [15:0] stall_pat;
    hold_left = 0;
    phase = 0;
    stall_pat = '1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= stall_pat[phase % 16];
        phase++;
        if (phase == 64) begin
          phase = 0;
          case ($urandom_range(0, 3))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom) | 16'h0001;
            2: stall_pat = 16'($urandom & $urandom) | 16'h0001;
            default: stall_pat = ~16'($urandom & $urandom) | 16'h0001;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (gen_rows_due.size() == 0) begin
        $error("row word with none due: row_number %0d", out_ch.row_number);
        bad_words++;
      end else begin
        want = gen_rows_due.pop_front();
        if (out_ch.next_row_bits !== want.next_row_bits) begin
          $error("next_row_bits: expected %h, got %h", want.next_row_bits, out_ch.next_row_bits);
          bad_words++;
        end
        if (out_ch.row_number !== want.row_number) begin
          $error("row_number: expected %0d, got %0d", want.row_number, out_ch.row_number);
          bad_words++;
        end
        if (out_ch.end_of_generation !== want.end_of_generation) begin
          $error("end_of_generation: expected %b, got %b", want.end_of_generation,
                 out_ch.end_of_generation);
          bad_words++;
        end
        if (out_ch.generation_stable !== want.generation_stable) begin
          $error("generation_stable: expected %b, got %b", want.generation_stable,
                 out_ch.generation_stable);
          bad_words++;
        end
        if (out_ch.last_of_burst !== want.last_of_burst) begin
          $error("last_of_burst: expected %b, got %b", want.last_of_burst, out_ch.last_of_burst);
          bad_words++;
        end
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_GRID_WIDTH;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.row_bits <= '0;
    grid_w      = GRID_WIDTH_RST;
    grid_h      = GRID_HEIGHT_RST;
    row_above   = '0;
    row_mid     = '0;
    rows_taken  = 0;
    cells_moved = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_generations(340);
    test_backpressure();
    test_tallest();
    settle_idle();
    repeat (8) @(posedge clk);
    if (bad_words == 0) begin
      $display("life_generation_row_stepper_unit: match");
    end else begin
      $display("life_generation_row_stepper_unit: mismatch");
    end
    $finish;
  end

endmodule
